>>> design/scpm_pkg.sv
package scpm_pkg;

  localparam int NumPorts  = 4;
  localparam int PortW     = $clog2(NumPorts);
  localparam int BankDepth = 8;
  localparam int EntryW    = $clog2(BankDepth);
  localparam int DelayW    = 12;
  localparam int ByteW     = 8;

  // protocol bytes
  localparam logic [ByteW-1:0] ByteStartMask = 8'h01;
  localparam logic [ByteW-1:0] HdrId         = 8'h80;
  localparam logic [ByteW-1:0] HdrAck        = 8'h5A;
  localparam logic [ByteW-1:0] CmdPoll       = 8'h42;
  localparam logic [ByteW-1:0] CardMask      = 8'hF0;

  // acknowledge delays
  localparam logic [DelayW-1:0] AckFirst = 12'd1000;
  localparam logic [DelayW-1:0] AckPad   = 12'h040;
  localparam logic [DelayW-1:0] AckCard  = 12'h020;

  // byte positions within a full-mode frame
  localparam logic [ByteW-1:0] ByteStart    = 8'd0;
  localparam logic [ByteW-1:0] ByteHdrId    = 8'd1;
  localparam logic [ByteW-1:0] ByteHdrAck   = 8'd2;
  localparam logic [ByteW-1:0] ByteCmdFirst = 8'd3;
  localparam logic [ByteW-1:0] ByteDelayEnd = 8'd10;
  localparam logic [ByteW-1:0] ByteCmdEnd   = 8'd11;
  localparam logic [ByteW-1:0] ByteDone     = 8'd33;
  localparam logic [ByteW-1:0] ByteAckEnd   = 8'd34;
  localparam logic [ByteW-1:0] ByteReplyEnd = 8'd35;
  localparam logic [ByteW-1:0] ByteSat      = 8'd255;

  typedef enum logic {
    ACT_CLOCK  = 1'b0,
    ACT_SELECT = 1'b1
  } action_e;

  typedef struct packed {
    logic              cmd_clear;
    logic              cmd_write;
    logic              reply_fill;
    logic              reply_clear;
    logic [EntryW-1:0] entry;
    logic [2:0]        bit_sel;
    logic [ByteW-1:0]  wdata;
    logic              pad_en;
    logic              card_en;
  } lane_ctl_t;

  typedef struct packed {
    logic              cmd_bit;
    logic              reply_bit;
    logic [DelayW-1:0] pad_delay;
    logic [DelayW-1:0] card_delay;
  } lane_res_t;

  typedef struct packed {
    logic [NumPorts-1:0] cmd_bits;
    logic                reply_bit;
    logic [DelayW-1:0]   pad_max;
    logic [NumPorts-1:0] pad_zero;
    logic [DelayW-1:0]   port_delay;
  } merge_t;

endpackage

>>> design/scpm_lane.sv
module scpm_lane import scpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctl_t         ctl_i,
  input  logic              pad_resp_i,
  input  logic [DelayW-1:0] pad_delay_i,
  input  logic [DelayW-1:0] card_delay_i,
  output lane_res_t         res_o
);

  logic [ByteW-1:0] cmd_q   [BankDepth];
  logic [ByteW-1:0] cmd_d   [BankDepth];
  logic [ByteW-1:0] reply_q [BankDepth];
  logic [ByteW-1:0] reply_d [BankDepth];
  logic             reply_old;
  logic             reply_drop;

  assign reply_old  = reply_q[ctl_i.entry][ctl_i.bit_sel];
  assign reply_drop = ctl_i.reply_clear && !pad_resp_i;

  always_comb begin
    cmd_d   = cmd_q;
    reply_d = reply_q;
    if (ctl_i.cmd_clear) begin
      for (int k = 0; k < BankDepth; k++) cmd_d[k] = '0;
      cmd_d[0] = CmdPoll;
    end else if (ctl_i.cmd_write) begin
      cmd_d[ctl_i.entry] = ctl_i.wdata;
    end
    if (ctl_i.reply_fill) begin
      for (int k = 0; k < BankDepth; k++) reply_d[k] = '1;
    end else if (reply_drop) begin
      reply_d[ctl_i.entry][ctl_i.bit_sel] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BankDepth; k++) begin
        cmd_q[k]   <= '0;
        reply_q[k] <= '0;
      end
    end else begin
      cmd_q   <= cmd_d;
      reply_q <= reply_d;
    end
  end

  // reply bit as seen after this transfer's clearing
  assign res_o.cmd_bit    = cmd_q[ctl_i.entry][ctl_i.bit_sel];
  assign res_o.reply_bit  = reply_old && !reply_drop;
  assign res_o.pad_delay  = ctl_i.pad_en  ? pad_delay_i  : '0;
  assign res_o.card_delay = ctl_i.card_en ? card_delay_i : '0;

endmodule

>>> design/scpm_merge.sv
module scpm_merge import scpm_pkg::*; (
  input  lane_res_t        res_i [NumPorts],
  input  logic [PortW-1:0] bank_i,
  input  logic [PortW-1:0] port_i,
  output merge_t           merge_o
);

  logic [DelayW-1:0] port_pad;
  logic [DelayW-1:0] port_card;

  assign port_pad  = res_i[port_i].pad_delay;
  assign port_card = res_i[port_i].card_delay;

  always_comb begin
    merge_o.pad_max = AckPad;
    for (int k = 0; k < NumPorts; k++) begin
      merge_o.cmd_bits[k] = res_i[k].cmd_bit;
      merge_o.pad_zero[k] = (res_i[k].pad_delay == '0);
      if (res_i[k].pad_delay > merge_o.pad_max) merge_o.pad_max = res_i[k].pad_delay;
    end
    merge_o.reply_bit  = res_i[bank_i].reply_bit;
    merge_o.port_delay = (port_pad > port_card) ? port_pad : port_card;
  end

endmodule

>>> design/serial_controller_port_multiplexer.sv
// Four-port hub on a bit-serial, select-framed host link. One input transfer
// is either a select line change (tuser high) or one clocked host bit (tuser
// low), and every input transfer yields exactly one output transfer. A new
// input transfer is taken every clock cycle; the result is held in a single
// output register and appears in the cycle after acceptance. Input stalls only
// while that output register is full and not being taken. Each port has its
// own lane with an 8-byte command bank and an 8-byte reply bank; the lanes
// work in parallel and a merge stage picks the reply bit and combines the
// acknowledge delays.
module serial_controller_port_multiplexer import scpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // txd_bit, select_level, pad_response[3:0], card_response[3:0],
  // pad_delays[47:0], card_delays[47:0], zero fill
  input  logic [111:0] s_axis_tdata,
  // action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // host_bit, pad_clock_enable[3:0], card_clock_enable[3:0], pad_tx_bits[3:0],
  // card_tx_bit, sub_select, ack_valid, ack_delay[11:0], zero fill
  output logic [31:0]  m_axis_tdata
);

  // input fields
  action_e                  action;
  logic                     txd;
  logic                     lvl;
  logic [NumPorts-1:0]      padr;
  logic [NumPorts-1:0]      cardr;
  logic [NumPorts*DelayW-1:0] pd;
  logic [NumPorts*DelayW-1:0] cd;

  assign action = action_e'(s_axis_tuser);
  assign txd    = s_axis_tdata[0];
  assign lvl    = s_axis_tdata[1];
  assign padr   = s_axis_tdata[5:2];
  assign cardr  = s_axis_tdata[9:6];
  assign pd     = s_axis_tdata[57:10];
  assign cd     = s_axis_tdata[105:58];

  // state
  logic             sel_q, sel_d;
  logic             pc_ok_q, pc_ok_d;
  logic [PortW-1:0] pc_q, pc_d;
  logic [2:0]       bit_q, bit_d;
  logic [ByteW-1:0] rx_q, rx_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             card_q, card_d;
  logic             frame_q, frame_d;
  logic             fmr_q, fmr_d;
  logic             lfd_q, lfd_d;
  logic [NumPorts-1:0] present_q, present_d;
  logic             abort_q, abort_d;

  // output register
  logic        out_valid_q;
  logic [31:0] out_data_q, out_data_d;

  logic accept;
  logic clk_item;
  logic sel_item;
  logic byte_end;
  logic [ByteW-1:0] rx_new;
  logic [ByteW-1:0] j;
  logic in_reply;
  logic cmd_drive;
  logic m_bit;
  logic [NumPorts-1:0] pen, cen;
  logic ctx;
  logic [3:0] nib;
  logic card_new, frame_new, pc_ok_new;
  logic [PortW-1:0] pc_new;

  lane_ctl_t lane_ctl [NumPorts];
  lane_res_t lane_res [NumPorts];
  merge_t    mrg;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clk_item      = accept && (action == ACT_CLOCK) && sel_q;
  assign sel_item      = accept && (action == ACT_SELECT);
  assign byte_end      = (bit_q == 3'd7);
  assign j             = byte_q - ByteCmdFirst;
  assign in_reply      = (byte_q >= ByteCmdFirst) && (byte_q < ByteReplyEnd);
  assign cmd_drive     = frame_q && !abort_q && (byte_q >= ByteCmdFirst) &&
                         (byte_q < ByteCmdEnd);

  always_comb begin
    rx_new        = rx_q;
    rx_new[bit_q] = txd;
  end

  // byte 0 decode of card mode and port choice
  assign nib       = rx_new[3:0];
  assign card_new  = |(rx_new & CardMask);
  assign frame_new = frame_q && !card_new;
  assign pc_ok_new = frame_new || ((nib != 4'd0) && (nib <= 4'(NumPorts)));
  assign pc_new    = frame_new ? '0 : PortW'(nib - 4'd1);

  // clock enables toward the ports
  always_comb begin
    pen   = '0;
    cen   = '0;
    ctx   = 1'b0;
    m_bit = (bit_q < 3'd4) ? ByteStartMask[bit_q] : txd;
    if (byte_q == ByteStart) begin
      pen = '1;
      cen = '1;
      ctx = m_bit;
    end else if (frame_q) begin
      if (cmd_drive) pen = '1;
    end else if (pc_ok_q) begin
      pen[pc_q] = 1'b1;
      cen[pc_q] = 1'b1;
      ctx       = txd;
    end
  end

  for (genvar k = 0; k < NumPorts; k++) begin : g_lane
    always_comb begin
      lane_ctl[k].cmd_clear   = sel_item && lvl && !sel_q && !lfd_q;
      lane_ctl[k].cmd_write   = clk_item && byte_end && frame_q && in_reply &&
                                (j[EntryW +: PortW] == PortW'(k));
      lane_ctl[k].reply_fill  = clk_item && byte_end && (byte_q == ByteStart) &&
                                frame_new;
      lane_ctl[k].reply_clear = clk_item && cmd_drive;
      lane_ctl[k].entry       = j[EntryW-1:0];
      lane_ctl[k].bit_sel     = bit_q;
      lane_ctl[k].wdata       = rx_new;
      lane_ctl[k].pad_en      = pen[k];
      lane_ctl[k].card_en     = cen[k];
    end

    scpm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (lane_ctl[k]),
      .pad_resp_i   (padr[k]),
      .pad_delay_i  (pd[k*DelayW +: DelayW]),
      .card_delay_i (cd[k*DelayW +: DelayW]),
      .res_o        (lane_res[k])
    );
  end

  scpm_merge u_merge (
    .res_i   (lane_res),
    .bank_i  (j[EntryW +: PortW]),
    .port_i  ((byte_q == ByteStart) ? pc_new : pc_q),
    .merge_o (mrg)
  );

  // next state and result
  always_comb begin
    logic             host;
    logic [NumPorts-1:0] ptx;
    logic             ackv;
    logic [DelayW-1:0] ackd;
    logic [ByteW-1:0] bcn;

    sel_d     = sel_q;
    pc_ok_d   = pc_ok_q;
    pc_d      = pc_q;
    bit_d     = bit_q;
    rx_d      = rx_q;
    byte_d    = byte_q;
    card_d    = card_q;
    frame_d   = frame_q;
    fmr_d     = fmr_q;
    lfd_d     = lfd_q;
    present_d = present_q;
    abort_d   = abort_q;
    host      = 1'b1;
    ptx       = '0;
    ackv      = 1'b0;
    ackd      = '0;
    bcn       = byte_q;

    if (sel_item) begin
      sel_d = lvl;
      if (!lvl) begin
        bit_d   = '0;
        rx_d    = '0;
        pc_ok_d = 1'b0;
        card_d  = 1'b0;
        frame_d = 1'b0;
      end else if (!sel_q) begin
        frame_d = fmr_q;
        lfd_d   = 1'b0;
        byte_d  = '0;
      end
    end else if (clk_item) begin
      rx_d  = rx_new;
      bit_d = bit_q + 3'd1;
      if (byte_q == ByteStart) begin
        ptx = {NumPorts{m_bit}};
      end else if (frame_q) begin
        if (byte_q == ByteHdrId) begin
          host = HdrId[bit_q];
        end else if (byte_q == ByteHdrAck) begin
          host = HdrAck[bit_q];
        end else if (in_reply) begin
          if (cmd_drive) ptx = mrg.cmd_bits;
          host = mrg.reply_bit;
        end
      end else if (pc_ok_q) begin
        ptx[pc_q] = txd;
        host      = padr[pc_q] & cardr[pc_q];
      end

      if (byte_end) begin
        if (byte_q == ByteStart) begin
          card_d  = card_new;
          frame_d = frame_new;
          pc_ok_d = pc_ok_new;
          pc_d    = pc_new;
        end
        if (byte_q == ByteHdrId) abort_d = frame_q && (rx_new != CmdPoll);
        if ((!card_d || frame_d) && byte_q == ByteHdrAck) fmr_d = rx_new[0];
        if (frame_d && byte_q == ByteDone) lfd_d = 1'b1;

        if (frame_d) begin
          if (byte_q == ByteStart) begin
            ackv      = 1'b1;
            ackd      = AckFirst;
            present_d = ~mrg.pad_zero;
          end else if (byte_q == ByteHdrId) begin
            ackv = 1'b1;
            ackd = AckPad;
          end else if (byte_q == ByteHdrAck) begin
            ackv = 1'b1;
            if (present_q != '0) begin
              ackd = AckPad;
            end else begin
              bcn  = ByteSat;
              ackd = '0;
            end
          end else if (byte_q >= ByteCmdFirst && byte_q < ByteAckEnd) begin
            ackv = 1'b1;
            if (byte_q < ByteDelayEnd) begin
              ackd = mrg.pad_max;
              // a present pad that stays silent after the first command byte
              if (byte_q == ByteCmdFirst && |(present_q & mrg.pad_zero)) abort_d = 1'b1;
            end else begin
              ackd = AckCard;
            end
            if (byte_q == ByteCmdFirst && abort_d) begin
              bcn  = ByteSat;
              ackd = '0;
            end
          end
        end else if (pc_ok_d) begin
          ackv = 1'b1;
          ackd = mrg.port_delay;
        end
        byte_d = (bcn != ByteSat) ? bcn + 8'd1 : bcn;
      end
    end

    out_data_d = {4'b0, ackd, ackv, sel_d, ctx & clk_item, ptx,
                  clk_item ? cen : '0, clk_item ? pen : '0, host};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= 1'b0;
      pc_ok_q   <= 1'b0;
      pc_q      <= '0;
      bit_q     <= '0;
      rx_q      <= '0;
      byte_q    <= '0;
      card_q    <= 1'b0;
      frame_q   <= 1'b0;
      fmr_q     <= 1'b0;
      lfd_q     <= 1'b0;
      present_q <= '0;
      abort_q   <= 1'b0;
    end else begin
      sel_q     <= sel_d;
      pc_ok_q   <= pc_ok_d;
      pc_q      <= pc_d;
      bit_q     <= bit_d;
      rx_q      <= rx_d;
      byte_q    <= byte_d;
      card_q    <= card_d;
      frame_q   <= frame_d;
      fmr_q     <= fmr_d;
      lfd_q     <= lfd_d;
      present_q <= present_d;
      abort_q   <= abort_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
